>>> hdl/time_triggered_task_scheduler_assert.svh
// assertion macros for the task scheduler
`ifndef TIME_TRIGGERED_TASK_SCHEDULER_ASSERT_SVH
`define TIME_TRIGGERED_TASK_SCHEDULER_ASSERT_SVH
`ifndef SYNTH
// same-cycle implication, disabled during reset
`define TTS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");
// next-cycle implication, disabled during reset
`define TTS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler check failed");
`else
`define TTS_ASSERT_IMP(lbl, ante, cons)
`define TTS_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hdl/tts_pkg.sv
`default_nettype none
package tts_pkg;

  // command codes of an input item
  typedef enum logic [1:0] {
    CMD_TICK     = 2'd0,
    CMD_ADD      = 2'd1,
    CMD_REMOVE   = 2'd2,
    CMD_DISPATCH = 2'd3
  } cmd_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_SLOT = 2'd2,
    ST_IDLE     = 2'd3
  } status_t;

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_SCAN,
    S_REMOVE,
    S_FINISH
  } state_t;

  // one table entry as held in the slot memory
  typedef struct packed {
    logic [15:0] code;
    logic [31:0] dly;
    logic [31:0] per;
    logic [7:0]  pend;
  } slot_entry_t;

  // most run results one dispatch may return
  localparam int RESULT_CAP = 8;
  localparam int CNT_W = $clog2(RESULT_CAP + 1);

endpackage
`default_nettype wire

>>> hdl/time_triggered_task_scheduler.sv
// tick and dispatch walk the slot memory, add scans the valid marks for the lowest free slot and
// remove needs no walk; results are registered, and every result may wait on output stalls
// one item at a time: a new item is taken only once the sequencer is back in idle;
// the walk over the slot memory takes a read state and an update state for each slot it visits
// reset: synchronous, clears the valid marks, sequencer and output valid;
// slot memory contents are not cleared, an entry without its valid mark is never used
`default_nettype none
`include "time_triggered_task_scheduler_assert.svh"
module time_triggered_task_scheduler #(
  parameter int NUM_SLOTS = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [1:0]  cmd,
  input  wire logic [2:0]  slot,
  input  wire logic [15:0] task_code,
  input  wire logic [31:0] delay,
  input  wire logic [31:0] period,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             run,
  output logic [2:0]       out_slot,
  output logic [15:0]      out_code,
  output logic [1:0]       status,
  output logic             last
);
  import tts_pkg::*;

  localparam int IW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_SLOTS - 1);
  localparam logic [CNT_W-1:0] CAP_M1 = CNT_W'(RESULT_CAP - 1);

  // sequencer and table control
  state_t                 state, state_next;
  logic [IW-1:0]          idx, idx_next;
  logic [NUM_SLOTS-1:0]   valid, valid_next;
  logic                   hold_vld, hold_vld_next;
  logic [IW-1:0]          hold_slot, hold_slot_next;
  logic [15:0]            hold_code, hold_code_next;
  logic [CNT_W-1:0]       run_cnt, run_cnt_next;

  // latched item
  cmd_t                   c_cmd;
  logic [2:0]             c_slot;
  logic [15:0]            c_code;
  logic [31:0]            c_dly;
  logic [31:0]            c_per;

  // output register
  logic                   out_valid_next;
  logic                   run_next, last_next;
  logic [2:0]             out_slot_next;
  logic [15:0]            out_code_next;
  logic [1:0]             status_next;

  // slot memory port
  logic                   mem_we, mem_re;
  slot_entry_t            mem_wdata, mem_rdata;

  // shared update unit
  logic                   dly_zero;
  logic [31:0]            dly_dec;
  logic [7:0]             pend_inc, pend_dec;
  logic                   out_free, in_acc, sel_ok;
  logic [IW-1:0]          sel_idx;

  tts_slot_mem #(
    .DEPTH (NUM_SLOTS),
    .AW    (IW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (idx),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (idx),
    .rdata (mem_rdata)
  );

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  // arithmetic on the entry under work
  assign dly_zero = (mem_rdata.dly == 32'd0);
  assign dly_dec  = mem_rdata.dly - 32'd1;
  assign pend_inc = (mem_rdata.pend == 8'hFF) ? mem_rdata.pend : mem_rdata.pend + 8'd1;
  assign pend_dec = mem_rdata.pend - 8'd1;

  // remove target check
  assign sel_idx = IW'(c_slot);
  assign sel_ok  = ({29'd0, c_slot} < 32'(NUM_SLOTS)) && valid[sel_idx];

  // next state, table updates and results
  always_comb begin
    state_next     = state;
    idx_next       = idx;
    valid_next     = valid;
    hold_vld_next  = hold_vld;
    hold_slot_next = hold_slot;
    hold_code_next = hold_code;
    run_cnt_next   = run_cnt;
    mem_we         = 1'b0;
    mem_re         = 1'b0;
    mem_wdata      = mem_rdata;
    out_valid_next = out_valid && !out_ready;
    run_next       = run;
    out_slot_next  = out_slot;
    out_code_next  = out_code;
    status_next    = status;
    last_next      = last;
    case (state)
      S_IDLE: begin
        if (in_valid) begin
          idx_next      = '0;
          hold_vld_next = 1'b0;
          run_cnt_next  = '0;
          case (cmd_t'(cmd))
            CMD_ADD:    state_next = S_SCAN;
            CMD_REMOVE: state_next = S_REMOVE;
            default:    state_next = S_READ;
          endcase
        end
      end
      S_READ: begin
        mem_re     = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        if (c_cmd == CMD_TICK) begin
          // advance delay, count a run when it expires
          if (valid[idx]) begin
            mem_we = 1'b1;
            if (dly_zero) begin
              mem_wdata.pend = pend_inc;
              if (mem_rdata.per != 32'd0) begin
                mem_wdata.dly = mem_rdata.per;
              end
            end else begin
              mem_wdata.dly = dly_dec;
            end
          end
          if (idx == LAST_IDX) begin
            state_next = S_IDLE;
          end else begin
            idx_next   = idx + IW'(1);
            state_next = S_READ;
          end
        end else if (valid[idx] && (mem_rdata.pend != 8'd0)) begin
          // dispatch hit: release the held result, hold this one
          if (!hold_vld || out_free) begin
            if (hold_vld) begin
              out_valid_next = 1'b1;
              run_next       = 1'b1;
              out_slot_next  = 3'(hold_slot);
              out_code_next  = hold_code;
              status_next    = ST_OK;
              last_next      = 1'b0;
            end
            hold_vld_next  = 1'b1;
            hold_slot_next = idx;
            hold_code_next = mem_rdata.code;
            run_cnt_next   = run_cnt + CNT_W'(1);
            if (mem_rdata.per == 32'd0) begin
              valid_next[idx] = 1'b0;
            end else begin
              mem_we         = 1'b1;
              mem_wdata.pend = pend_dec;
            end
            if ((run_cnt == CAP_M1) || (idx == LAST_IDX)) begin
              state_next = S_FINISH;
            end else begin
              idx_next   = idx + IW'(1);
              state_next = S_READ;
            end
          end
        end else if (idx == LAST_IDX) begin
          state_next = S_FINISH;
        end else begin
          idx_next   = idx + IW'(1);
          state_next = S_READ;
        end
      end
      S_FINISH: begin
        // final dispatch result, or idle when nothing ran
        if (out_free) begin
          out_valid_next = 1'b1;
          last_next      = 1'b1;
          if (hold_vld) begin
            run_next      = 1'b1;
            out_slot_next = 3'(hold_slot);
            out_code_next = hold_code;
            status_next   = ST_OK;
          end else begin
            run_next      = 1'b0;
            out_slot_next = 3'd0;
            out_code_next = 16'd0;
            status_next   = ST_IDLE;
          end
          hold_vld_next = 1'b0;
          state_next    = S_IDLE;
        end
      end
      S_SCAN: begin
        // lowest free slot takes the new task
        if (!valid[idx]) begin
          if (out_free) begin
            mem_we          = 1'b1;
            mem_wdata.code  = c_code;
            mem_wdata.dly   = c_dly;
            mem_wdata.per   = c_per;
            mem_wdata.pend  = 8'd0;
            valid_next[idx] = 1'b1;
            out_valid_next  = 1'b1;
            run_next        = 1'b0;
            out_slot_next   = 3'(idx);
            out_code_next   = 16'd0;
            status_next     = ST_OK;
            last_next       = 1'b1;
            state_next      = S_IDLE;
          end
        end else if (idx == LAST_IDX) begin
          if (out_free) begin
            out_valid_next = 1'b1;
            run_next       = 1'b0;
            out_slot_next  = 3'd0;
            out_code_next  = 16'd0;
            status_next    = ST_FULL;
            last_next      = 1'b1;
            state_next     = S_IDLE;
          end
        end else begin
          idx_next = idx + IW'(1);
        end
      end
      S_REMOVE: begin
        if (out_free) begin
          if (sel_ok) begin
            valid_next[sel_idx] = 1'b0;
            status_next         = ST_OK;
          end else begin
            status_next = ST_BAD_SLOT;
          end
          out_valid_next = 1'b1;
          run_next       = 1'b0;
          out_slot_next  = c_slot;
          out_code_next  = 16'd0;
          last_next      = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      valid     <= '0;
      hold_vld  <= 1'b0;
      run_cnt   <= '0;
      out_valid <= 1'b0;
      idx       <= '0;
    end else begin
      state     <= state_next;
      valid     <= valid_next;
      hold_vld  <= hold_vld_next;
      run_cnt   <= run_cnt_next;
      out_valid <= out_valid_next;
      idx       <= idx_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    hold_slot <= hold_slot_next;
    hold_code <= hold_code_next;
    run       <= run_next;
    out_slot  <= out_slot_next;
    out_code  <= out_code_next;
    status    <= status_next;
    last      <= last_next;
    if (in_acc) begin
      c_cmd  <= cmd_t'(cmd);
      c_slot <= slot;
      c_code <= task_code;
      c_dly  <= delay;
      c_per  <= period;
    end
  end

  // checks
  `TTS_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready)
  `TTS_ASSERT_IMP(a_run_is_ok, out_valid && run, status == ST_OK)
  `TTS_ASSERT_IMP(a_idle_is_final, out_valid && (status == ST_IDLE), last && !run)
  `TTS_ASSERT_IMP(a_run_cap, 1'b1, run_cnt <= CNT_W'(RESULT_CAP))
  `TTS_ASSERT_IMP(a_no_hold_when_idle, in_ready, !hold_vld)

endmodule
`default_nettype wire

>>> hdl/tts_slot_mem.sv
`default_nettype none
module tts_slot_mem #(
  parameter int DEPTH = 8,
  parameter int AW = 3
) (
  input  wire logic                clk,
  input  wire logic                we,
  input  wire logic [AW-1:0]       waddr,
  input  wire tts_pkg::slot_entry_t wdata,
  input  wire logic                re,
  input  wire logic [AW-1:0]       raddr,
  output tts_pkg::slot_entry_t     rdata
);
  import tts_pkg::*;

  slot_entry_t mem [DEPTH];

  // single write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port, holds its data between reads
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire
